@@ rtl/core/kdb_pkg.sv @@
// Package for the keypad and switch debounce scanner: types, register codes,
// reset values and the per-input debounce step. No dependencies.
`default_nettype none

package kdb_pkg;

	// default geometry
	localparam int NUM_SWITCHES_DEF = 4;
	localparam int KEY_ROWS_DEF     = 4;
	localparam int KEY_COLS_DEF     = 4;

	// counter and register widths
	localparam int CNT_W      = 9;
	localparam int DT_W       = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CNT_W-1:0] CNT_MAX       = 9'd511;
	localparam logic [DT_W-1:0]  DEBOUNCE_RST  = 8'd30;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SW_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KP_ENABLE = 2'd2;

	// event codes
	localparam logic EV_SRC_SWITCH = 1'b0;
	localparam logic EV_SRC_KEY    = 1'b1;
	localparam logic EV_PRESS      = 1'b0;
	localparam logic EV_RELEASE    = 1'b1;

	// depth of the queue between the front and the back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [DT_W-1:0] debounce_ticks;
		logic            switch_enable;
		logic            keypad_enable;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             down;
		logic             press_ev;
		logic             release_ev;
	} dbn_res_t;

	// width of the event position field
	function automatic int pos_width(int nk, int ns);
		int w;
		w = $clog2(nk);
		if ($clog2(ns) > w) w = $clog2(ns);
		if (w < 1) w = 1;
		return w;
	endfunction

	// one debounce update for a single switch or key
	function automatic dbn_res_t debounce_step(logic level, logic [CNT_W-1:0] cnt, logic down,
			logic [DT_W-1:0] dt);
		dbn_res_t r;
		r.cnt        = cnt;
		r.down       = down;
		r.press_ev   = 1'b0;
		r.release_ev = 1'b0;
		if (!level) begin
			r.cnt = '0;
			if (down) begin
				r.down       = 1'b0;
				r.release_ev = 1'b1;
			end
		end else if (!down) begin
			if (cnt != CNT_MAX) r.cnt = cnt + 1'b1;
			if (cnt >= CNT_W'(dt)) begin
				r.down     = 1'b1;
				r.press_ev = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/kdb_front.sv @@
// Front part of the scanner: takes scan ticks, updates the debounce counters and
// pressed flags of enabled inputs, and pushes the tick's event mask into the queue. Uses kdb_pkg.
`default_nettype none

module kdb_front #(
	parameter int NUM_SWITCHES = kdb_pkg::NUM_SWITCHES_DEF,
	parameter int KEY_ROWS     = kdb_pkg::KEY_ROWS_DEF,
	parameter int KEY_COLS     = kdb_pkg::KEY_COLS_DEF,
	localparam int NUM_KEYS    = KEY_ROWS * KEY_COLS,
	localparam int NUM_EV      = NUM_SWITCHES + NUM_KEYS
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  kdb_pkg::cfg_t          cfg,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire [NUM_SWITCHES-1:0] switch_levels,
	input  wire [NUM_KEYS-1:0]     key_levels,
	input  wire                    q_full,
	output logic                   push,
	output logic [NUM_EV-1:0]      push_mask,
	output logic [NUM_EV-1:0]      push_type
);
	import kdb_pkg::*;

	logic [CNT_W-1:0] sw_cnt_q  [NUM_SWITCHES];
	logic             sw_down_q [NUM_SWITCHES];
	logic [CNT_W-1:0] key_cnt_q [NUM_KEYS];
	logic             key_down_q[NUM_KEYS];
	dbn_res_t         sw_res    [NUM_SWITCHES];
	dbn_res_t         key_res   [NUM_KEYS];
	logic             accept;
	logic             scan_keys;

	// transaction taken whenever the queue has room
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign scan_keys = !(|switch_levels) && cfg.keypad_enable;

	// next debounce state of every input
	always_comb begin
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			sw_res[i] = debounce_step(switch_levels[i], sw_cnt_q[i], sw_down_q[i],
				cfg.debounce_ticks);
		end
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_res[k] = debounce_step(key_levels[k], key_cnt_q[k], key_down_q[k],
				cfg.debounce_ticks);
		end
	end

	// debounce state, updated once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SWITCHES; i++) begin
				sw_cnt_q[i]  <= '0;
				sw_down_q[i] <= 1'b0;
			end
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_cnt_q[k]  <= '0;
				key_down_q[k] <= 1'b0;
			end
		end else if (accept) begin
			if (cfg.switch_enable) begin
				for (int i = 0; i < NUM_SWITCHES; i++) begin
					sw_cnt_q[i]  <= sw_res[i].cnt;
					sw_down_q[i] <= sw_res[i].down;
				end
			end
			if (scan_keys) begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					key_cnt_q[k]  <= key_res[k].cnt;
					key_down_q[k] <= key_res[k].down;
				end
			end
		end
	end

	// event slots: switches first, then keys column by column
	for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_sw_slot
		assign push_mask[i] = cfg.switch_enable && (sw_res[i].press_ev || sw_res[i].release_ev);
		assign push_type[i] = sw_res[i].release_ev ? EV_RELEASE : EV_PRESS;
	end
	for (genvar r = 0; r < KEY_ROWS; r++) begin : g_row
		for (genvar c = 0; c < KEY_COLS; c++) begin : g_col
			localparam int K    = r * KEY_COLS + c;
			localparam int SLOT = NUM_SWITCHES + c * KEY_ROWS + r;
			assign push_mask[SLOT] = scan_keys && (key_res[K].press_ev || key_res[K].release_ev);
			assign push_type[SLOT] = key_res[K].release_ev ? EV_RELEASE : EV_PRESS;
		end
	end

	// ticks without events leave nothing in the queue
	assign push = accept && (|push_mask);

endmodule

`default_nettype wire

@@ rtl/core/kdb_queue.sv @@
// Short queue of pending event masks between the front and the back.
// Register based; uses kdb_pkg for its depth.
`default_nettype none

module kdb_queue #(
	parameter int W = 2
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire  [W-1:0] push_data,
	output logic         full,
	input  wire          pop,
	output logic [W-1:0] head_data,
	output logic         not_empty
);
	import kdb_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	logic [W-1:0]       data_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W_Q'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_data = data_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) data_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/kdb_back.sv @@
// Back part of the scanner: takes event masks from the queue and sends the
// events out one per cycle while out_stall is low, through the output register. Uses kdb_pkg.
`default_nettype none

module kdb_back #(
	parameter int NUM_SWITCHES = kdb_pkg::NUM_SWITCHES_DEF,
	parameter int KEY_ROWS     = kdb_pkg::KEY_ROWS_DEF,
	parameter int KEY_COLS     = kdb_pkg::KEY_COLS_DEF,
	localparam int NUM_KEYS    = KEY_ROWS * KEY_COLS,
	localparam int NUM_EV      = NUM_SWITCHES + NUM_KEYS,
	localparam int POS_W       = kdb_pkg::pos_width(NUM_KEYS, NUM_SWITCHES)
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_not_empty,
	input  wire  [NUM_EV-1:0] q_mask,
	input  wire  [NUM_EV-1:0] q_type,
	output logic              q_pop,
	output logic              out_valid,
	input  wire               out_stall,
	output logic              event_source,
	output logic              event_type,
	output logic [POS_W-1:0]  position,
	output logic              last
);
	import kdb_pkg::*;

	logic [POS_W-1:0]  slot_pos [NUM_EV];
	logic [NUM_EV-1:0] slot_src;
	logic              cur_valid_q;
	logic [NUM_EV-1:0] cur_mask_q;
	logic [NUM_EV-1:0] cur_type_q;
	logic              out_valid_q;
	logic              src_q;
	logic              type_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;
	logic [NUM_EV-1:0] lowbit;
	logic [NUM_EV-1:0] rest;
	logic              out_free;
	logic              emit;
	logic              cur_done;
	logic              load;
	logic              sel_src;
	logic              sel_type;
	logic [POS_W-1:0]  sel_pos;

	// source and position of each event slot
	for (genvar j = 0; j < NUM_EV; j++) begin : g_slot
		if (j < NUM_SWITCHES) begin : g_sw
			assign slot_pos[j] = POS_W'(j);
			assign slot_src[j] = EV_SRC_SWITCH;
		end else begin : g_key
			localparam int K = j - NUM_SWITCHES;
			assign slot_pos[j] = POS_W'((K % KEY_ROWS) * KEY_COLS + K / KEY_ROWS);
			assign slot_src[j] = EV_SRC_KEY;
		end
	end

	// lowest pending event of the current tick
	assign lowbit   = cur_mask_q & (~cur_mask_q + 1'b1);
	assign rest     = cur_mask_q & ~lowbit;
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = cur_valid_q && out_free;
	assign cur_done = emit && (rest == '0);
	assign load     = (!cur_valid_q || cur_done) && q_not_empty;
	assign q_pop    = load;

	always_comb begin
		sel_src  = 1'b0;
		sel_type = 1'b0;
		sel_pos  = '0;
		for (int j = 0; j < NUM_EV; j++) begin
			if (lowbit[j]) begin
				sel_src  = sel_src | slot_src[j];
				sel_type = sel_type | cur_type_q[j];
				sel_pos  = sel_pos | slot_pos[j];
			end
		end
	end

	// working mask of the tick being sent out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
		end else if (cur_done) begin
			cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_mask_q <= q_mask;
			cur_type_q <= q_type;
		end else if (emit) begin
			cur_mask_q <= rest;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			src_q  <= sel_src;
			type_q <= sel_type;
			pos_q  <= sel_pos;
			last_q <= (rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign event_source = src_q;
	assign event_type   = type_q;
	assign position     = pos_q;
	assign last         = last_q;

endmodule

`default_nettype wire

@@ rtl/core/keypad_switch_debounce_scanner.sv @@
// Keypad and switch debounce scanner. Each accepted scan tick updates the debounce
// counters and pressed flags of enabled switches and scanned keys in the cycle it
// is taken, so ticks can be accepted back to back; the tick's events then leave one
// per cycle while out_stall is low, through the output register, switches first and
// keys column by column, with last set on the final event of the tick. A tick has
// at most NUM_SWITCHES + KEY_ROWS*KEY_COLS events, 20 by default; a tick with no
// events puts nothing in the queue. The event serializer sets the rate, and a
// two-tick queue between the debounce front and the serializer means in_stall rises
// only when two ticks' events are still waiting. Configuration writes are always ready.
// Top level; uses kdb_pkg, kdb_front, kdb_queue and kdb_back.
`default_nettype none

module keypad_switch_debounce_scanner #(
	parameter int NUM_SWITCHES = kdb_pkg::NUM_SWITCHES_DEF,
	parameter int KEY_ROWS     = kdb_pkg::KEY_ROWS_DEF,
	parameter int KEY_COLS     = kdb_pkg::KEY_COLS_DEF,
	localparam int NUM_KEYS    = KEY_ROWS * KEY_COLS,
	localparam int POS_W       = kdb_pkg::pos_width(NUM_KEYS, NUM_SWITCHES)
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration write channel
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [kdb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [kdb_pkg::CFG_DATA_W-1:0]    cfg_data,
	// scan tick input
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [NUM_SWITCHES-1:0]           switch_levels,
	input  wire  [NUM_KEYS-1:0]               key_levels,
	// event output
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              event_source,
	output logic                              event_type,
	output logic [POS_W-1:0]                  position,
	output logic                              last
);
	import kdb_pkg::*;

	localparam int NUM_EV = NUM_SWITCHES + NUM_KEYS;

	cfg_t                cfg_q;
	logic                push;
	logic [NUM_EV-1:0]   push_mask;
	logic [NUM_EV-1:0]   push_type;
	logic                q_full;
	logic                q_pop;
	logic                q_not_empty;
	logic [2*NUM_EV-1:0] q_head;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.switch_enable  <= 1'b0;
			cfg_q.keypad_enable  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:  cfg_q.debounce_ticks <= cfg_data[DT_W-1:0];
				REG_SW_ENABLE: cfg_q.switch_enable  <= cfg_data[0];
				REG_KP_ENABLE: cfg_q.keypad_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// debounce front
	kdb_front #(
		.NUM_SWITCHES(NUM_SWITCHES),
		.KEY_ROWS(KEY_ROWS),
		.KEY_COLS(KEY_COLS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.switch_levels(switch_levels),
		.key_levels(key_levels),
		.q_full(q_full),
		.push(push),
		.push_mask(push_mask),
		.push_type(push_type)
	);

	// pending ticks
	kdb_queue #(
		.W(2 * NUM_EV)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_type, push_mask}),
		.full(q_full),
		.pop(q_pop),
		.head_data(q_head),
		.not_empty(q_not_empty)
	);

	// event serializer
	kdb_back #(
		.NUM_SWITCHES(NUM_SWITCHES),
		.KEY_ROWS(KEY_ROWS),
		.KEY_COLS(KEY_COLS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_mask(q_head[NUM_EV-1:0]),
		.q_type(q_head[2*NUM_EV-1:NUM_EV]),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_source(event_source),
		.event_type(event_type),
		.position(position),
		.last(last)
	);

endmodule

`default_nettype wire

@@ rtl/core/kdb_checker.sv @@
// Port-level checks for the scanner, bound to the top level.
// Depends on keypad_switch_debounce_scanner only through its ports.
`default_nettype none

module kdb_checker #(
	parameter int NUM_SWITCHES = 4,
	parameter int POS_W        = 4
) (
	input wire             clk,
	input wire             arst_n,
	input wire             out_valid,
	input wire             out_stall,
	input wire             event_source,
	input wire [POS_W-1:0] position,
	input wire             last
);

	// output register comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("event valid right after reset");

	// a stalled event holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) &&
			$stable(event_source) && $stable(last))
		else $error("stalled event changed");

	// events of one tick follow without gaps
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a tick's events");

	// keypad events never precede switch events within a tick
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last && event_source |=> event_source)
		else $error("switch event after keypad event in one tick");

	// switch positions stay within the switch count
	a_sw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_source |-> ({1'b0, position} < (POS_W + 1)'(NUM_SWITCHES)))
		else $error("switch event position out of range");

endmodule

bind keypad_switch_debounce_scanner kdb_checker #(
	.NUM_SWITCHES(NUM_SWITCHES),
	.POS_W(POS_W)
) u_kdb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.event_source(event_source),
	.position(position),
	.last(last)
);

`default_nettype wire

@@ tb/sv/keypad_event_checker.sv @@
// Event checker for the keypad and switch debounce scanner: watches the register,
// scan tick and event channels, predicts the events of each tick and compares them.
// Depends on kdb_pkg for widths and event codes.
`default_nettype none

module keypad_event_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	input  wire                            cfg_ready,
	input  wire [kdb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [kdb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                            in_valid,
	input  wire                            in_stall,
	input  wire [3:0]                      switch_levels,
	input  wire [15:0]                     key_levels,
	input  wire                            out_valid,
	input  wire                            out_stall,
	input  wire                            event_source,
	input  wire                            event_type,
	input  wire [3:0]                      position,
	input  wire                            last,
	output int                             fail_count,
	output int                             events_outstanding
);

	import kdb_pkg::*;

	localparam int N_SW   = 4;
	localparam int N_ROWS = 4;
	localparam int N_COLS = 4;
	localparam int N_KEYS = N_ROWS * N_COLS;

	typedef enum logic [1:0] {CHANGE_NONE, CHANGE_PRESS, CHANGE_RELEASE} key_change_e;

	typedef struct packed {
		logic       src;
		logic       kind;
		logic [3:0] pos;
		logic       last;
	} scan_event_t;

	// predicted register and debounce state
	logic [DT_W-1:0]  hold_ticks;
	logic             sw_en;
	logic             kp_en;
	logic [CNT_W-1:0] sw_count [N_SW];
	logic             sw_held [N_SW];
	logic [CNT_W-1:0] key_count [N_KEYS];
	logic             key_held [N_KEYS];

	scan_event_t expected_events [$];
	int          n_fail;

	// one debounce update of a single switch or key
	task automatic debounce_update(input logic level, inout logic [CNT_W-1:0] cnt,
			inout logic held, output key_change_e change);
		logic [CNT_W-1:0] prior;
		change = CHANGE_NONE;
		prior  = cnt;
		if (!level) begin
			cnt = '0;
			if (held) begin
				held   = 1'b0;
				change = CHANGE_RELEASE;
			end
		end else if (!held) begin
			if (prior != CNT_MAX)
				cnt = prior + 1'b1;
			if (prior >= {1'b0, hold_ticks}) begin
				held   = 1'b1;
				change = CHANGE_PRESS;
			end
		end
	endtask

	// events of one scan tick, switches first, then keys column by column
	task automatic predict_tick_events(input logic [3:0] sw, input logic [15:0] keys);
		scan_event_t      tick_ev [N_SW + N_KEYS];
		scan_event_t      ev;
		key_change_e      change;
		logic [CNT_W-1:0] cnt;
		logic             held;
		int               n;
		int               k;
		n = 0;
		if (sw_en) begin
			for (int i = 0; i < N_SW; i++) begin
				cnt  = sw_count[i];
				held = sw_held[i];
				debounce_update(sw[i], cnt, held, change);
				sw_count[i] = cnt;
				sw_held[i]  = held;
				if (change != CHANGE_NONE) begin
					tick_ev[n].src  = EV_SRC_SWITCH;
					tick_ev[n].kind = (change == CHANGE_PRESS) ? EV_PRESS : EV_RELEASE;
					tick_ev[n].pos  = 4'(i);
					tick_ev[n].last = 1'b0;
					n++;
				end
			end
		end
		// any high switch blocks the keypad scan, enabled or not
		if (sw == '0 && kp_en) begin
			for (int col = 0; col < N_COLS; col++) begin
				for (int row = 0; row < N_ROWS; row++) begin
					k    = row * N_COLS + col;
					cnt  = key_count[k];
					held = key_held[k];
					debounce_update(keys[k], cnt, held, change);
					key_count[k] = cnt;
					key_held[k]  = held;
					if (change != CHANGE_NONE) begin
						tick_ev[n].src  = EV_SRC_KEY;
						tick_ev[n].kind = (change == CHANGE_PRESS) ? EV_PRESS : EV_RELEASE;
						tick_ev[n].pos  = 4'(k);
						tick_ev[n].last = 1'b0;
						n++;
					end
				end
			end
		end
		for (int j = 0; j < n; j++) begin
			ev      = tick_ev[j];
			ev.last = (j == n - 1);
			expected_events.push_back(ev);
		end
	endtask

	// compare one event transaction with the oldest prediction
	task automatic check_event();
		scan_event_t got;
		scan_event_t want;
		got.src  = event_source;
		got.kind = event_type;
		got.pos  = position;
		got.last = last;
		if (expected_events.size() == 0) begin
			if (n_fail < 10)
				$display("unexpected event: src %0d type %0d pos %0d last %0d",
					got.src, got.kind, got.pos, got.last);
			n_fail++;
		end else begin
			want = expected_events.pop_front();
			if (got != want) begin
				if (n_fail < 10)
					$display("event mismatch: expected src %0d type %0d pos %0d last %0d,",
						want.src, want.kind, want.pos, want.last,
						" got src %0d type %0d pos %0d last %0d",
						got.src, got.kind, got.pos, got.last);
				n_fail++;
			end
		end
	endtask

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks = DEBOUNCE_RST;
			sw_en      = 1'b0;
			kp_en      = 1'b0;
			for (int i = 0; i < N_SW; i++) begin
				sw_count[i] = '0;
				sw_held[i]  = 1'b0;
			end
			for (int i = 0; i < N_KEYS; i++) begin
				key_count[i] = '0;
				key_held[i]  = 1'b0;
			end
			expected_events.delete();
			n_fail             = 0;
			fail_count         <= 0;
			events_outstanding <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_event();
			// the tick sees the registers as they were before this edge
			if (in_valid && !in_stall)
				predict_tick_events(switch_levels, key_levels);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE:  hold_ticks = cfg_data[DT_W-1:0];
					REG_SW_ENABLE: sw_en      = cfg_data[0];
					REG_KP_ENABLE: kp_en      = cfg_data[0];
					default: ;
				endcase
			end
			fail_count         <= n_fail;
			events_outstanding <= expected_events.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_keypad_switch_debounce_scanner.sv @@
// Testbench top for the keypad and switch debounce scanner: clock, reset, register
// writes, scan tick stimulus and random stalls, with the verdict at the end.
// Depends on kdb_pkg, keypad_event_checker and the scanner RTL.
`default_nettype none

module tb_keypad_switch_debounce_scanner;

	import kdb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_TICKS = 30;
	localparam int LONG_TICKS   = 22;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic [3:0]            switch_levels = '0;
	logic [15:0]           key_levels = '0;
	logic                  out_stall = 1'b0;

	wire                   cfg_ready;
	wire                   in_stall;
	wire                   out_valid;
	wire                   event_source;
	wire                   event_type;
	wire [3:0]             position;
	wire                   last;

	int fail_count;
	int events_outstanding;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	logic [3:0]  held_sw;
	logic [15:0] held_keys;

	keypad_switch_debounce_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.switch_levels(switch_levels),
		.key_levels   (key_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_source (event_source),
		.event_type   (event_type),
		.position     (position),
		.last         (last)
	);

	keypad_event_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.switch_levels     (switch_levels),
		.key_levels        (key_levels),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.event_source      (event_source),
		.event_type        (event_type),
		.position          (position),
		.last              (last),
		.fail_count        (fail_count),
		.events_outstanding(events_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// random back-pressure on the event output
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// one register write transaction; valid is left high for a following write
	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [DT_W-1:0] dt, input logic sw_on, input logic kp_on);
		cfg_put(REG_DEBOUNCE, CFG_DATA_W'(dt));
		cfg_put(REG_SW_ENABLE, CFG_DATA_W'(sw_on));
		cfg_put(REG_KP_ENABLE, CFG_DATA_W'(kp_on));
		cfg_valid <= 1'b0;
	endtask

	// one scan tick transaction, with an optional idle gap in front of it
	task automatic send_tick(input logic [3:0] sw, input logic [15:0] keys);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		switch_levels <= sw;
		key_levels    <= keys;
		do @(posedge clk); while (in_stall);
	endtask

	// let every predicted event drain, then give empty ticks time to clear
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly slowly changing levels so counters get to fire, with some noise
	task automatic run_random(input int n_ticks);
		int r;
		for (int t = 0; t < n_ticks; t++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				held_sw   = 4'($urandom);
				held_keys = 16'($urandom);
			end else if (r < 14) begin
				held_sw   = '0;
				held_keys = '0;
			end else begin
				for (int b = 0; b < 16; b++)
					if ($urandom_range(99) < 15)
						held_keys[b] = ~held_keys[b];
				if (held_sw == '0) begin
					if ($urandom_range(99) < 6)
						held_sw[2'($urandom_range(3))] = 1'b1;
				end else if ($urandom_range(99) < 40) begin
					held_sw = '0;
				end else begin
					for (int b = 0; b < 4; b++)
						if ($urandom_range(99) < 20)
							held_sw[b] = ~held_sw[b];
				end
			end
			send_tick(held_sw, held_keys);
		end
	endtask

	initial begin
		held_sw   = '0;
		held_keys = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both parts disabled after reset: no events at all
		send_tick(4'hF, 16'hFFFF);
		send_tick(4'h0, 16'hFFFF);
		send_tick(4'h0, 16'h0000);
		wait_idle();

		// no debounce, write to the unused index must be ignored
		cfg_put(REG_DEBOUNCE, 8'd0);
		cfg_put(REG_SW_ENABLE, 8'd1);
		cfg_put(REG_KP_ENABLE, 8'd1);
		cfg_put(REG_UNUSED, 8'hFF);
		cfg_valid <= 1'b0;
		send_tick(4'h0, 16'hFFFF);
		send_tick(4'h0, 16'h0000);
		send_tick(4'hF, 16'hFFFF);
		// full tick: four switch releases and sixteen key presses
		send_tick(4'h0, 16'hFFFF);
		send_tick(4'h8, 16'h0000);
		send_tick(4'h0, 16'h8001);
		send_tick(4'h0, 16'h0000);
		send_tick(4'h0, 16'h0000);
		wait_idle();

		// a disabled switch still blocks the keypad scan
		configure(8'd0, 1'b0, 1'b1);
		send_tick(4'h2, 16'hFFFF);
		send_tick(4'h0, 16'hFFFF);
		send_tick(4'h0, 16'h0000);
		wait_idle();

		// debounce lowered while a key is counting
		configure(8'd3, 1'b1, 1'b1);
		send_tick(4'h0, 16'h0001);
		send_tick(4'h0, 16'h0001);
		wait_idle();
		configure(8'd1, 1'b1, 1'b1);
		send_tick(4'h0, 16'h0001);
		send_tick(4'h0, 16'h0000);
		wait_idle();

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					configure(8'd1, 1'b1, 1'b1);
				end
				1: begin
					send_idle_pct  = 58;
					recv_stall_pct = 0;
					configure(8'd3, 1'b1, 1'b1);
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 58;
					configure(8'd0, 1'b0, 1'b1);
				end
				default: begin
					send_idle_pct  = 18;
					recv_stall_pct = 18;
					configure(8'($urandom_range(4)), 1'b1, 1'b0);
				end
			endcase
			run_random(RANDOM_TICKS);
			wait_idle();
		end

		// long debounce: keys then switches held until they fire
		configure(8'd20, 1'b1, 1'b1);
		send_tick(4'h0, 16'h0000);
		for (int t = 0; t < LONG_TICKS; t++)
			send_tick(4'h0, 16'hFFFF);
		send_tick(4'h0, 16'h5A5A);
		for (int t = 0; t < LONG_TICKS; t++)
			send_tick(4'hF, 16'h0000);
		send_tick(4'h0, 16'h0000);
		wait_idle();

		if (fail_count == 0 && events_outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// overall time limit
	initial begin
		#1600000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
